/* sv/dqd_pkg.sv */
package dqd_pkg;

   localparam int NUM_CLASSES = 11;
   localparam int CLASS_W     = 4;
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_THRESHOLD    = 2'd2;

   localparam logic [13:0] IMAGE_WIDTH_RESET  = 14'd1024;
   localparam logic [13:0] IMAGE_HEIGHT_RESET = 14'd1024;
   localparam logic [15:0] THRESHOLD_RESET    = 16'd32768;

   // Sigmoid table holds entries 0 through 12; magnitudes at or above 12.0 saturate.
   localparam logic [7:0] SIG_SAT_INDEX = 8'd12;

   typedef struct packed {
      logic signed [15:0] logit;
      logic [CLASS_W-1:0] cls;
      logic [15:0]        cx;
      logic [15:0]        cy;
      logic [15:0]        bw;
      logic [15:0]        bh;
   } dqd_query_type;

   typedef struct packed {
      logic [13:0] image_width;
      logic [13:0] image_height;
      logic [15:0] threshold;
   } dqd_cfg_type;

   typedef struct packed {
      logic [17:0]        bottom;
      logic [17:0]        right;
      logic [17:0]        top;
      logic [17:0]        left;
      logic [15:0]        score;
      logic [CLASS_W-1:0] cls;
   } dqd_result_type;

   function automatic logic [15:0] sig_table(input logic [3:0] idx);
      logic [15:0] val;
      case (idx)
         4'd0:    val = 16'd32768;
         4'd1:    val = 16'd47911;
         4'd2:    val = 16'd57724;
         4'd3:    val = 16'd62428;
         4'd4:    val = 16'd64357;
         4'd5:    val = 16'd65097;
         4'd6:    val = 16'd65374;
         4'd7:    val = 16'd65476;
         4'd8:    val = 16'd65514;
         4'd9:    val = 16'd65528;
         4'd10:   val = 16'd65533;
         4'd11:   val = 16'd65535;
         default: val = 16'd65535;
      endcase
      return val;
   endfunction

endpackage

/* sv/dqd_front.sv */
module dqd_front
   import dqd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [79:0]   req_tdata,
   input  logic          req_tlast,
   input  logic          queue_full,
   output logic          push_valid,
   output dqd_query_type push_query
);

   logic signed [15:0] best_logit_ff, best_logit_in;
   logic [CLASS_W-1:0] best_class_ff, best_class_in;
   logic [CLASS_W-1:0] count_ff, count_in;
   logic               overrun_ff, overrun_in;

   logic               accept;
   logic signed [15:0] logit;
   logic               take;
   logic signed [15:0] run_logit;
   logic [CLASS_W-1:0] run_class;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign logit      = $signed(req_tdata[15:0]);

   always_comb begin
      take      = !overrun_ff && (logit > best_logit_ff);
      run_logit = take ? logit : best_logit_ff;
      run_class = take ? count_ff : best_class_ff;

      best_logit_in = best_logit_ff;
      best_class_in = best_class_ff;
      count_in      = count_ff;
      overrun_in    = overrun_ff;
      if (accept) begin
         if (req_tlast) begin
            best_logit_in = 16'sh8000;
            best_class_in = '0;
            count_in      = '0;
            overrun_in    = 1'b0;
         end else begin
            best_logit_in = run_logit;
            best_class_in = run_class;
            if (!overrun_ff) begin
               if (count_ff >= CLASS_W'(NUM_CLASSES - 1)) begin
                  overrun_in = 1'b1;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
      end

      push_valid       = accept && req_tlast;
      push_query.logit = run_logit;
      push_query.cls   = run_class;
      push_query.cx    = req_tdata[31:16];
      push_query.cy    = req_tdata[47:32];
      push_query.bw    = req_tdata[63:48];
      push_query.bh    = req_tdata[79:64];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_logit_ff <= 16'sh8000;
         best_class_ff <= '0;
         count_ff      <= '0;
         overrun_ff    <= 1'b0;
      end else begin
         best_logit_ff <= best_logit_in;
         best_class_ff <= best_class_in;
         count_ff      <= count_in;
         overrun_ff    <= overrun_in;
      end
   end

endmodule

/* sv/dqd_queue.sv */
module dqd_queue
   import dqd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  dqd_query_type push_data,
   input  logic          pop,
   output logic          full,
   output logic          empty,
   output dqd_query_type head
);

   dqd_query_type         entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full    = count_ff == FIFO_CNT_W'(FIFO_DEPTH);
   assign empty   = count_ff == '0;
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* sv/dqd_back.sv */
module dqd_back
   import dqd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dqd_cfg_type   cfg,
   input  logic          queue_empty,
   input  dqd_query_type head,
   output logic          pop,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [95:0]   rsp_tdata
);

   // Corner value in 2^-17 pixel, clamped to [0, size << 17], rounded half up to Q14.4.
   function automatic logic [17:0] clamp_round(input logic signed [33:0] v,
                                               input logic [13:0] size);
      logic signed [33:0] lim;
      logic signed [33:0] c;
      logic signed [33:0] sum;
      lim = $signed({3'b000, size, 17'd0});
      if (v < 0) begin
         c = '0;
      end else if (v > lim) begin
         c = lim;
      end else begin
         c = v;
      end
      sum = c + 34'sd4096;
      return sum[30:13];
   endfunction

   logic adv;

   // stage 1: table lookup, interpolation product and corner products
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_neg_ff, s1_neg_in;
   logic               s1_sat_ff, s1_sat_in;
   logic [15:0]        s1_base_ff, s1_base_in;
   logic [21:0]        s1_interp_ff, s1_interp_in;
   logic [CLASS_W-1:0] s1_cls_ff;
   logic signed [33:0] s1_pl_ff, s1_pl_in;
   logic signed [33:0] s1_pr_ff, s1_pr_in;
   logic signed [33:0] s1_pt_ff, s1_pt_in;
   logic signed [33:0] s1_pb_ff, s1_pb_in;

   // stage 2: score and rounded corners
   logic               s2_valid_ff, s2_valid_in;
   logic               s2_conf_ok_ff, s2_conf_ok_in;
   dqd_result_type     s2_res_ff, s2_res_in;

   // output register
   logic               out_valid_ff, out_valid_in;
   dqd_result_type     out_res_ff;

   logic [16:0]        mag;
   logic [3:0]         idx;
   logic [15:0]        diff;
   logic signed [18:0] dl, dr, dt, db;
   logic signed [14:0] sw, sh;
   logic [22:0]        interp_rnd;
   logic [16:0]        pos;
   logic [16:0]        score_full;

   assign adv = !out_valid_ff || rsp_tready;
   assign pop = adv && !queue_empty;

   always_comb begin
      s1_neg_in  = head.logit[15];
      mag        = s1_neg_in ? 17'(-$signed({head.logit[15], head.logit}))
                             : 17'($signed({head.logit[15], head.logit}));
      s1_sat_in  = mag[15:8] >= SIG_SAT_INDEX;
      idx        = mag[11:8];
      s1_base_in = sig_table(idx);
      diff       = sig_table(idx + 4'd1) - s1_base_in;
      s1_interp_in = diff[13:0] * mag[7:0];

      dl = $signed({2'b00, head.cx, 1'b0}) - $signed({3'b000, head.bw});
      dr = $signed({2'b00, head.cx, 1'b0}) + $signed({3'b000, head.bw});
      dt = $signed({2'b00, head.cy, 1'b0}) - $signed({3'b000, head.bh});
      db = $signed({2'b00, head.cy, 1'b0}) + $signed({3'b000, head.bh});
      sw = $signed({1'b0, cfg.image_width});
      sh = $signed({1'b0, cfg.image_height});
      s1_pl_in = dl * sw;
      s1_pr_in = dr * sw;
      s1_pt_in = dt * sh;
      s1_pb_in = db * sh;
      s1_valid_in = adv ? !queue_empty : s1_valid_ff;
   end

   always_comb begin
      interp_rnd = {1'b0, s1_interp_ff} + 23'd128;
      pos = s1_sat_ff ? 17'd65535 : {1'b0, s1_base_ff} + 17'(interp_rnd[22:8]);
      score_full = s1_neg_ff ? 17'h10000 - pos : pos;

      s2_res_in.cls    = s1_cls_ff;
      s2_res_in.score  = score_full[15:0];
      s2_res_in.left   = clamp_round(s1_pl_ff, cfg.image_width);
      s2_res_in.right  = clamp_round(s1_pr_ff, cfg.image_width);
      s2_res_in.top    = clamp_round(s1_pt_ff, cfg.image_height);
      s2_res_in.bottom = clamp_round(s1_pb_ff, cfg.image_height);
      s2_conf_ok_in    = score_full[15:0] >= cfg.threshold;
      s2_valid_in      = adv ? s1_valid_ff : s2_valid_ff;

      // A box with no area after clamping is dropped.
      out_valid_in = out_valid_ff;
      if (adv) begin
         out_valid_in = s2_valid_ff && s2_conf_ok_ff &&
                        (s2_res_ff.right > s2_res_ff.left) &&
                        (s2_res_ff.bottom > s2_res_ff.top);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_neg_ff     <= s1_neg_in;
         s1_sat_ff     <= s1_sat_in;
         s1_base_ff    <= s1_base_in;
         s1_interp_ff  <= s1_interp_in;
         s1_cls_ff     <= head.cls;
         s1_pl_ff      <= s1_pl_in;
         s1_pr_ff      <= s1_pr_in;
         s1_pt_ff      <= s1_pt_in;
         s1_pb_ff      <= s1_pb_in;
         s2_res_ff     <= s2_res_in;
         s2_conf_ok_ff <= s2_conf_ok_in;
         out_res_ff    <= s2_res_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_res_ff};

endmodule

/* sv/detection_query_decode_unit.sv */
// A tlast request reaches rsp via the queue, stage 1, stage 2 and the output register. One
// request is taken per cycle while the queue is not full; the argmax register updates once
// per accepted request, and the decode pipeline behind the four-entry queue advances one
// query per cycle unless stalled. A dropped query leaves a bubble and produces no response.
// Reset (synchronous, active high) clears the argmax state, empties the queue and pipeline,
// and loads image size 1024 x 1024 and threshold 0.5.
module detection_query_decode_unit
   import dqd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // class_logit[15:0], box_center_x[31:16], box_center_y[47:32],
   // box_width[63:48], box_height[79:64]
   input  logic [79:0] req_tdata,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // class_index[3:0], score[19:4], left_edge[37:20], top_edge[55:38],
   // right_edge[73:56], bottom_edge[91:74], zero fill[95:92]
   output logic [95:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   dqd_cfg_type   cfg_ff, cfg_in;
   logic          queue_full, queue_empty, push_valid, pop;
   dqd_query_type push_query, head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  cfg_in.image_width  = csr_wdata[13:0];
            CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_wdata[13:0];
            CSR_THRESHOLD:    cfg_in.threshold    = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= IMAGE_WIDTH_RESET;
         cfg_ff.image_height <= IMAGE_HEIGHT_RESET;
         cfg_ff.threshold    <= THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dqd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_query (push_query)
   );

   dqd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_query),
      .pop       (pop),
      .full      (queue_full),
      .empty     (queue_empty),
      .head      (head)
   );

   dqd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

/* sv/dqd_checker.sv */
module dqd_checker
   import dqd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata
);

   // A response waiting for the sink keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Every delivered box has positive width and height.
   a_box_area: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[73:56] > rsp_tdata[37:20]) &&
                     (rsp_tdata[91:74] > rsp_tdata[55:38]))
      else $error("response box has no area");

   a_class_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[3:0] < CLASS_W'(NUM_CLASSES))
      else $error("class index out of range");

   // Reset empties the pipeline and the queue.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("state not cleared by reset");

endmodule

bind detection_query_decode_unit dqd_checker u_dqd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
